@@ hdl/mdo_pkg.sv @@
// Package for the Minkowski distance block: field widths, root sizes,
// sequencer state type and the accumulator control bundle.
// No dependencies.
package mdo_pkg;

  // Request field widths
  localparam int unsigned COORD_W = 16;

  // Running sums and result fields
  localparam int unsigned SUM_ABS_W  = 23;
  localparam int unsigned SUM_SQ_W   = 40;
  localparam int unsigned SUM_CUBE_W = 56;
  localparam int unsigned DIST_W     = 36;
  localparam int unsigned CHEB_W     = 16;

  // Fixed point: 16 fraction bits on each root
  localparam int unsigned SQ_FRAC_SHIFT   = 32;
  localparam int unsigned CUBE_FRAC_SHIFT = 48;

  // One result bit per root iteration
  localparam int unsigned ROOT_ITERS = DIST_W;
  localparam int unsigned ITER_W     = $clog2(ROOT_ITERS);

  // Defaults for the top level parameters
  localparam int unsigned MAX_LEN_DEF     = 128;
  localparam int unsigned COORD_WIDTH_DEF = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_CUBE,
    ST_ACC,
    ST_RSTART,
    ST_ROOT,
    ST_EMIT
  } mdo_state_t;

  typedef struct packed {
    logic load;      // capture |x-y| of a new request
    logic mul_sq;    // multiplier forms |d|^2
    logic mul_cube;  // multiplier forms |d|^3
    logic acc;       // add into the running sums
    logic clear;     // return all sums to zero
  } acc_ctrl_t;

endpackage

@@ hdl/mdo_accum.sv @@
// Pair accumulator: |x-y|, shared multiplier for square and cube,
// saturating running sums and running maximum. Depends on mdo_pkg.
module mdo_accum #(
  parameter int unsigned MAX_LEN     = mdo_pkg::MAX_LEN_DEF,
  parameter int unsigned COORD_WIDTH = mdo_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  mdo_pkg::acc_ctrl_t               ctrl,
  input  logic [mdo_pkg::COORD_W-1:0]      x_coord,
  input  logic [mdo_pkg::COORD_W-1:0]      y_coord,
  output logic [mdo_pkg::SUM_ABS_W-1:0]    sum_abs,
  output logic [mdo_pkg::SUM_SQ_W-1:0]     sum_square,
  output logic [mdo_pkg::SUM_CUBE_W-1:0]   sum_cube,
  output logic [COORD_WIDTH-1:0]           max_abs,
  output logic                             saturated
);
  import mdo_pkg::*;

  localparam int unsigned CW    = COORD_WIDTH;
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);

  logic signed [CW:0]    x_ext, y_ext, diff;
  logic [CW:0]           diff_neg;
  logic [CW-1:0]         abs_in;
  logic [CW-1:0]         a_reg;
  logic [2*CW-1:0]       sq_reg;
  logic [3*CW-1:0]       cube_reg;
  logic [2*CW-1:0]       mul_a;
  logic [3*CW-1:0]       product;
  logic [CNT_W-1:0]      pair_count;
  logic                  full_run;
  logic [SUM_ABS_W:0]    abs_add;
  logic [SUM_SQ_W:0]     sq_add;
  logic [SUM_CUBE_W:0]   cube_add;

  // low COORD_WIDTH bits taken as two's complement
  assign x_ext    = {x_coord[CW-1], x_coord[CW-1:0]};
  assign y_ext    = {y_coord[CW-1], y_coord[CW-1:0]};
  assign diff     = x_ext - y_ext;
  assign diff_neg = -diff;
  assign abs_in   = diff[CW] ? diff_neg[CW-1:0] : diff[CW-1:0];

  // one multiplier: a*a, then (a*a)*a
  assign mul_a   = ctrl.mul_cube ? sq_reg : (2*CW)'(a_reg);
  assign product = (3*CW)'(mul_a) * (3*CW)'(a_reg);

  assign full_run = (pair_count >= CNT_W'(MAX_LEN));
  assign abs_add  = {1'b0, sum_abs}    + (SUM_ABS_W+1)'(a_reg);
  assign sq_add   = {1'b0, sum_square} + (SUM_SQ_W+1)'(sq_reg);
  assign cube_add = {1'b0, sum_cube}   + (SUM_CUBE_W+1)'(cube_reg);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_reg <= abs_in;
    end
    if (ctrl.mul_sq) begin
      sq_reg <= product[2*CW-1:0];
    end
    if (ctrl.mul_cube) begin
      cube_reg <= product;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      sum_abs    <= '0;
      sum_square <= '0;
      sum_cube   <= '0;
      max_abs    <= '0;
      pair_count <= '0;
      saturated  <= 1'b0;
    end else begin
      if (ctrl.load && (abs_in > max_abs)) begin
        max_abs <= abs_in;
      end
      if (ctrl.acc) begin
        if (full_run) begin
          // run too long: pin every sum at full scale
          saturated  <= 1'b1;
          sum_abs    <= '1;
          sum_square <= '1;
          sum_cube   <= '1;
        end else begin
          pair_count <= pair_count + 1'b1;
          sum_abs    <= abs_add[SUM_ABS_W]   ? '1 : abs_add[SUM_ABS_W-1:0];
          sum_square <= sq_add[SUM_SQ_W]     ? '1 : sq_add[SUM_SQ_W-1:0];
          sum_cube   <= cube_add[SUM_CUBE_W] ? '1 : cube_add[SUM_CUBE_W-1:0];
          if (abs_add[SUM_ABS_W] || sq_add[SUM_SQ_W] || cube_add[SUM_CUBE_W]) begin
            saturated <= 1'b1;
          end
        end
      end
    end
  end

endmodule

@@ hdl/mdo_roots.sv @@
// Iterative root unit: square root and cube root, one result bit each per
// step (prepare, then decide), shift and add only. Depends on mdo_pkg.
module mdo_roots (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [mdo_pkg::SUM_SQ_W-1:0]    sum_square,
  input  logic [mdo_pkg::SUM_CUBE_W-1:0]  sum_cube,
  output logic                            done,
  output logic [mdo_pkg::DIST_W-1:0]      euclidean_dist,
  output logic [mdo_pkg::DIST_W-1:0]      cubic_dist
);
  import mdo_pkg::*;

  localparam int unsigned RAD2_W = 2 * DIST_W;        // radicand bits, square root
  localparam int unsigned REM2_W = DIST_W + 2;
  localparam int unsigned RAD3_W = 3 * DIST_W;        // radicand bits, cube root
  localparam int unsigned Y2_W   = 2 * DIST_W;
  localparam int unsigned B_W    = Y2_W + 3;
  localparam int unsigned REM3_W = B_W + 2;
  localparam int unsigned PAD3_W = RAD3_W - SUM_CUBE_W - CUBE_FRAC_SHIFT;

  logic                busy;
  logic                phase;     // 0: prepare cube step, 1: decide digit
  logic [ITER_W-1:0]   iter;

  logic [RAD2_W-1:0]   rad2;
  logic [REM2_W-1:0]   rem2;
  logic [DIST_W-1:0]   root2;
  logic [REM2_W+1:0]   rem2_sh, trial2, diff2;
  logic                take2;

  logic [RAD3_W-1:0]   rad3;
  logic [REM3_W-1:0]   rem3;
  logic [DIST_W-1:0]   root3;
  logic [Y2_W-1:0]     root3_sq;
  logic [B_W-1:0]      b_reg, b_sum, b_calc;
  logic                take3;

  // square root digit
  assign rem2_sh = {rem2, rad2[RAD2_W-1 -: 2]};
  assign trial2  = {2'b00, root2, 2'b01};
  assign diff2   = rem2_sh - trial2;
  assign take2   = (rem2_sh >= trial2);

  // cube root step term: 3*(y^2 + y) + 1 with y already doubled
  assign b_sum  = B_W'({root3_sq[Y2_W-3:0], 2'b00}) + B_W'({root3[DIST_W-2:0], 1'b0});
  assign b_calc = {b_sum[B_W-2:0], 1'b0} + b_sum + B_W'(1);
  assign take3  = (rem3 >= REM3_W'(b_reg));

  assign done           = busy && phase && (iter == ITER_W'(ROOT_ITERS - 1));
  assign euclidean_dist = root2;
  assign cubic_dist     = root3;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 1'b0;
      iter  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      phase <= 1'b0;
      iter  <= '0;
    end else if (busy) begin
      phase <= ~phase;
      if (phase) begin
        iter <= iter + 1'b1;
        if (done) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad2     <= {sum_square, {SQ_FRAC_SHIFT{1'b0}}};
      rem2     <= '0;
      root2    <= '0;
      rad3     <= {{PAD3_W{1'b0}}, sum_cube, {CUBE_FRAC_SHIFT{1'b0}}};
      rem3     <= '0;
      root3    <= '0;
      root3_sq <= '0;
    end else if (busy) begin
      if (!phase) begin
        // bring down three radicand bits, double the root
        rem3     <= {rem3[REM3_W-4:0], rad3[RAD3_W-1 -: 3]};
        rad3     <= {rad3[RAD3_W-4:0], 3'b000};
        root3    <= {root3[DIST_W-2:0], 1'b0};
        root3_sq <= {root3_sq[Y2_W-3:0], 2'b00};
        b_reg    <= b_calc;
      end else begin
        rad2 <= {rad2[RAD2_W-3:0], 2'b00};
        if (take2) begin
          rem2  <= diff2[REM2_W-1:0];
          root2 <= {root2[DIST_W-2:0], 1'b1};
        end else begin
          rem2  <= rem2_sh[REM2_W-1:0];
          root2 <= {root2[DIST_W-2:0], 1'b0};
        end
        if (take3) begin
          rem3     <= rem3 - REM3_W'(b_reg);
          root3    <= {root3[DIST_W-1:1], 1'b1};
          root3_sq <= root3_sq + Y2_W'({root3, 1'b1});
        end
      end
    end
  end

endmodule

@@ hdl/minkowski_distance_orders.sv @@
// Top level of the Minkowski distance block: request handshake, sequencer,
// result register. Uses mdo_pkg, mdo_accum and mdo_roots.
//
// Usage
//   Input stream s_*: one coordinate pair per request, x in s_tdata[15:0],
//   y in s_tdata[31:16], s_tlast high on the final pair of the two vectors.
//   Output stream m_*: one result per vector pair, sent after the s_tlast
//   request; overflow travels in m_tuser.
//   Each pair passes through capture, square, cube and accumulate on the
//   single multiplier; s_tready is high only while the sequencer is idle.
//   After the last pair the root unit runs 36 digits, each a prepare and
//   a decide step; the result is then loaded once the result register
//   is free.
//   The result register lets new pairs flow in while a result waits; a
//   following result holds in the sequencer until m_tready drains it.
//   Reset (rst, synchronous) empties the result register and zeroes every
//   sum, the maximum, the pair count and the overflow flag.
//   Past MAX_LEN pairs every sum holds at full scale; a sum that would wrap
//   holds there by itself; either way overflow is flagged for that vector pair.
module minkowski_distance_orders #(
  parameter int unsigned MAX_LEN     = mdo_pkg::MAX_LEN_DEF,
  parameter int unsigned COORD_WIDTH = mdo_pkg::COORD_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [31:0]   s_tdata,   // x_coord [15:0], y_coord [31:16]
  input  logic          s_tlast,   // last_pair
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [111:0]  m_tdata,   // manhattan_dist [22:0], euclidean_dist [58:23],
                                   // cubic_dist [94:59], chebyshev_dist [110:95], 0 [111]
  output logic          m_tuser    // overflow
);
  import mdo_pkg::*;

  mdo_state_t              state, state_next;
  acc_ctrl_t               ctrl;
  logic                    accept;
  logic                    last_reg;
  logic                    root_start;
  logic                    root_done;
  logic                    out_load;

  logic [SUM_ABS_W-1:0]    sum_abs;
  logic [SUM_SQ_W-1:0]     sum_square;
  logic [SUM_CUBE_W-1:0]   sum_cube;
  logic [COORD_WIDTH-1:0]  max_abs;
  logic                    saturated;
  logic [DIST_W-1:0]       euclid;
  logic [DIST_W-1:0]       cubic;

  logic [SUM_ABS_W-1:0]    manhattan_dist;
  logic [DIST_W-1:0]       euclidean_dist;
  logic [DIST_W-1:0]       cubic_dist;
  logic [CHEB_W-1:0]       chebyshev_dist;
  logic                    overflow;

  assign accept = s_tvalid && s_tready;

  mdo_accum #(
    .MAX_LEN     (MAX_LEN),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_accum (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .x_coord    (s_tdata[COORD_W-1:0]),
    .y_coord    (s_tdata[2*COORD_W-1:COORD_W]),
    .sum_abs    (sum_abs),
    .sum_square (sum_square),
    .sum_cube   (sum_cube),
    .max_abs    (max_abs),
    .saturated  (saturated)
  );

  mdo_roots u_roots (
    .clk            (clk),
    .rst            (rst),
    .start          (root_start),
    .sum_square     (sum_square),
    .sum_cube       (sum_cube),
    .done           (root_done),
    .euclidean_dist (euclid),
    .cubic_dist     (cubic)
  );

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept) state_next = ST_SQ;
      ST_SQ:     state_next = ST_CUBE;
      ST_CUBE:   state_next = ST_ACC;
      ST_ACC:    state_next = last_reg ? ST_RSTART : ST_IDLE;
      ST_RSTART: state_next = ST_ROOT;
      ST_ROOT:   if (root_done) state_next = ST_EMIT;
      ST_EMIT:   if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    s_tready      = (state == ST_IDLE);
    ctrl.load     = (state == ST_IDLE) && accept;
    ctrl.mul_sq   = (state == ST_SQ);
    ctrl.mul_cube = (state == ST_CUBE);
    ctrl.acc      = (state == ST_ACC);
    root_start    = (state == ST_RSTART);
    out_load      = (state == ST_EMIT) && (!m_tvalid || m_tready);
    ctrl.clear    = out_load;  // sums go back to zero once the result is held
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_reg <= s_tlast;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      manhattan_dist <= sum_abs;
      euclidean_dist <= euclid;
      cubic_dist     <= cubic;
      chebyshev_dist <= CHEB_W'(max_abs);
      overflow       <= saturated;
    end
  end

  assign m_tdata = {1'b0, chebyshev_dist, cubic_dist, euclidean_dist, manhattan_dist};
  assign m_tuser = overflow;

endmodule

@@ sim/mdo_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for minkowski_distance_orders. It rebuilds each vector's distances
// from the accepted s_* requests and checks the m_* results in order.
// Depends on mdo_pkg.
module mdo_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [31:0]  s_tdata,
  input  logic         s_tlast,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [111:0] m_tdata,
  input  logic         m_tuser,
  output int unsigned  fail_count,
  output int unsigned  pending_count
);
  import mdo_pkg::*;

  localparam longint unsigned ABS_TOP  = (64'd1 << SUM_ABS_W) - 1;
  localparam longint unsigned SQ_TOP   = (64'd1 << SUM_SQ_W) - 1;
  localparam longint unsigned CUBE_TOP = (64'd1 << SUM_CUBE_W) - 1;

  // Same order as {m_tuser, m_tdata[110:0]}
  typedef struct packed {
    logic                 overflow;
    logic [CHEB_W-1:0]    chebyshev;
    logic [DIST_W-1:0]    cubic;
    logic [DIST_W-1:0]    euclidean;
    logic [SUM_ABS_W-1:0] manhattan;
  } dist_result_t;

  dist_result_t results_due[$];

  bit [SUM_ABS_W-1:0]  acc_abs;
  bit [SUM_SQ_W-1:0]   acc_sq;
  bit [SUM_CUBE_W-1:0] acc_cube;
  bit [COORD_W-1:0]    peak_diff;
  int unsigned         pairs_seen;
  bit                  clipped;
  int unsigned         errs = 0;

  // Bit-serial floor root: largest r with r^2 (or r^3) <= target
  function automatic bit [DIST_W-1:0] fixed_root(input bit [127:0] target, input bit cube);
    bit [127:0] r;
    bit [127:0] c;
    bit [127:0] p;
    int         b;
    r = '0;
    for (b = DIST_W - 1; b >= 0; b--) begin
      c = r | (128'd1 << b);
      p = cube ? c * c * c : c * c;
      if (p <= target) r = c;
    end
    return r[DIST_W-1:0];
  endfunction

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin : monitor
    logic signed [COORD_W:0] diff;
    bit [COORD_W-1:0]        mag;
    bit [63:0]               total;
    dist_result_t            want;
    dist_result_t            got;

    if (rst) begin
      acc_abs    = '0;
      acc_sq     = '0;
      acc_cube   = '0;
      peak_diff  = '0;
      pairs_seen = 0;
      clipped    = 1'b0;
      results_due.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata[110:0]};
        if (results_due.size() == 0) begin
          $error("result with no vector end outstanding");
          errs++;
        end else begin
          want = results_due.pop_front();
          check_field("manhattan_dist", want.manhattan, got.manhattan);
          check_field("euclidean_dist", want.euclidean, got.euclidean);
          check_field("cubic_dist", want.cubic, got.cubic);
          check_field("chebyshev_dist", want.chebyshev, got.chebyshev);
          check_field("overflow", want.overflow, got.overflow);
        end
      end

      if (s_tvalid && s_tready) begin
        // coordinate width equals the field width, so every bit counts
        diff = $signed({s_tdata[15], s_tdata[15:0]}) - $signed({s_tdata[31], s_tdata[31:16]});
        mag  = (diff < 0) ? COORD_W'(-diff) : COORD_W'(diff);
        if (mag > peak_diff) peak_diff = mag;

        if (pairs_seen >= MAX_LEN_DEF) begin
          // vector too long: sums pinned at full scale
          clipped  = 1'b1;
          acc_abs  = '1;
          acc_sq   = '1;
          acc_cube = '1;
        end else begin
          pairs_seen++;
          total = 64'(acc_abs) + 64'(mag);
          if (total > ABS_TOP) begin
            clipped = 1'b1;
            acc_abs = '1;
          end else acc_abs = total[SUM_ABS_W-1:0];
          total = 64'(acc_sq) + 64'(mag) * 64'(mag);
          if (total > SQ_TOP) begin
            clipped = 1'b1;
            acc_sq  = '1;
          end else acc_sq = total[SUM_SQ_W-1:0];
          total = 64'(acc_cube) + 64'(mag) * 64'(mag) * 64'(mag);
          if (total > CUBE_TOP) begin
            clipped  = 1'b1;
            acc_cube = '1;
          end else acc_cube = total[SUM_CUBE_W-1:0];
        end

        if (s_tlast) begin
          want.manhattan = acc_abs;
          want.euclidean = fixed_root(128'(acc_sq) << SQ_FRAC_SHIFT, 1'b0);
          want.cubic     = fixed_root(128'(acc_cube) << CUBE_FRAC_SHIFT, 1'b1);
          want.chebyshev = peak_diff;
          want.overflow  = clipped;
          results_due    = {results_due, want};
          acc_abs    = '0;
          acc_sq     = '0;
          acc_cube   = '0;
          peak_diff  = '0;
          pairs_seen = 0;
          clipped    = 1'b0;
        end
      end
    end

    fail_count    <= errs;
    pending_count <= results_due.size();
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench top for minkowski_distance_orders: clock, reset, request and
// result stream drive, verdict. Depends on mdo_pkg and mdo_checker.
module tb_top;
  import mdo_pkg::*;

  // Random pairs after the directed vectors
  localparam int unsigned RANDOM_PAIRS = 930;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic [31:0]  s_tdata  = '0;
  logic         s_tlast  = 1'b0;
  logic         m_tready = 1'b0;
  wire          s_tready;
  wire          m_tvalid;
  wire  [111:0] m_tdata;
  wire          m_tuser;

  int unsigned fail_count;
  int unsigned pending_count;

  // Chance in a hundred that a side holds off
  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 81;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side back-pressure, one decision per cycle
  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

  minkowski_distance_orders u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // x_coord [15:0], y_coord [31:16]
    .s_tlast  (s_tlast),   // last_pair
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // manhattan [22:0], euclidean [58:23], cubic [94:59],
                           // chebyshev [110:95], 0 [111]
    .m_tuser  (m_tuser)    // overflow
  );

  mdo_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // One coordinate-pair request; returns at the falling edge after it is taken
  task automatic send_pair(input logic [15:0] x, input logic [15:0] y, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {y, x};
    s_tlast  = lst;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mix of full-range, rail and near-zero coordinates; rails only when asked
  function automatic logic [15:0] pick_coord(input bit rails_only);
    logic [15:0] v;
    if (rails_only) v = $urandom_range(1) ? 16'h7fff : 16'h8000;
    else begin
      case ($urandom_range(3))
        0:       v = $urandom_range(1) ? 16'h7fff : 16'h8000;
        1:       v = 16'($urandom_range(32)) - 16'd16;
        default: v = 16'($urandom());
      endcase
    end
    return v;
  endfunction

  initial begin : stimulus
    int unsigned sent;
    int unsigned vec;
    int unsigned len;
    int unsigned i;

    repeat (5) @(negedge clk);
    rst = 1'b0;

    // Single pairs: widest difference either way, zero, equal non-zero
    send_pair(16'h7fff, 16'h8000, 1'b1);
    send_pair(16'h8000, 16'h7fff, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'hffff, 16'hffff, 1'b1);
    // Short vectors mixing signs, rails and one-bit steps
    send_pair(16'd100, 16'hff9c, 1'b0);
    send_pair(16'hfffb, 16'd7, 1'b0);
    send_pair(16'd1, 16'd0, 1'b1);
    send_pair(16'h8000, 16'h8000, 1'b0);
    send_pair(16'h7fff, 16'h7fff, 1'b0);
    send_pair(16'd1, 16'hffff, 1'b1);
    send_pair(16'h7fff, 16'h0000, 1'b0);
    send_pair(16'h0000, 16'h8000, 1'b0);
    send_pair(16'h8000, 16'h0000, 1'b0);
    send_pair(16'h5555, 16'haaaa, 1'b1);

    // Random vectors. The first two sit at and just past the length limit
    // with rail coordinates; later ones are mostly short, with the odd long one.
    sent = 0;
    vec  = 0;
    while (sent < RANDOM_PAIRS) begin
      if (sent < RANDOM_PAIRS / 3) begin
        send_idle_pct = 11;
        recv_idle_pct = 81;
      end else if (sent < 2 * RANDOM_PAIRS / 3) begin
        send_idle_pct = 81;
        recv_idle_pct = 11;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (vec == 0) len = MAX_LEN_DEF;
      else if (vec == 1) len = MAX_LEN_DEF + 1;
      else if ($urandom_range(29) == 0) len = $urandom_range(MAX_LEN_DEF + 8, MAX_LEN_DEF - 2);
      else len = $urandom_range(8, 1);
      for (i = 0; i < len; i++)
        send_pair(pick_coord(vec < 2), pick_coord(vec < 2), i == len - 1);
      sent += len;
      vec++;
    end
    s_tvalid = 1'b0;

    // Drain, then leave room for any stray result to show up
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
